// File: rtl/fcsa_pkg.sv
// Shared types, codes and helper functions for the free cell stack allocator.
// No dependencies; imported by the divider and the allocator core.
package fcsa_pkg;

  localparam int unsigned RegW  = 5;
  localparam int unsigned CellW = 9;

  localparam int unsigned RowCountReset    = 16;
  localparam int unsigned ColumnCountReset = 16;

  localparam int unsigned DefMaxRows    = 16;
  localparam int unsigned DefMaxColumns = 16;
  localparam int unsigned DefStackDepth = 256;

  typedef logic [RegW-1:0]  reg_t;
  typedef logic [CellW-1:0] cell_t;

  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Result of the divider, valid for one cycle when done is high.
  typedef struct packed {
    logic  done;
    cell_t quot;
    reg_t  rem;
  } div_res_t;

  // Clamp a grid dimension to 1..max_v.
  function automatic reg_t clamp_dim(reg_t v, int unsigned max_v);
    reg_t res;
    if (v == '0) begin
      res = reg_t'(1);
    end else if (32'(v) > max_v) begin
      res = reg_t'(max_v);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Initial stack fill: rows times columns, limited to the stack depth.
  function automatic int unsigned grid_fill(reg_t r, reg_t c, int unsigned depth);
    int unsigned t;
    t = 32'(r) * 32'(c);
    return (t > depth) ? depth : t;
  endfunction

endpackage

// File: rtl/fcsa_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; holds the free stack of the allocator.
module fcsa_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: rtl/fcsa_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on fcsa_pkg for the cell and register types and the result struct.
module fcsa_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  fcsa_pkg::cell_t  dividend_i,
  input  fcsa_pkg::reg_t   divisor_i,
  output fcsa_pkg::div_res_t res_o
);
  import fcsa_pkg::*;

  localparam int unsigned CntW = $clog2(CellW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  cell_t           quot_q, quot_d;
  reg_t            rem_q, rem_d;
  reg_t            dvsr_q, dvsr_d;

  logic [RegW:0]   trial;
  logic [RegW:0]   diff;
  logic            ge;

  assign trial = {rem_q, quot_q[CellW-1]};
  assign ge    = trial >= {1'b0, dvsr_q};
  assign diff  = trial - {1'b0, dvsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvsr_d = divisor_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      quot_d = {quot_q[CellW-2:0], ge};
      rem_d  = ge ? diff[RegW-1:0] : trial[RegW-1:0];
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(CellW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

// File: rtl/free_cell_stack_allocator_core.sv
// Free cell stack allocator: LIFO of free cell numbers with row/column decode.
// Release, empty reserve and dropped release go from idle straight to the result load;
// a popping reserve first passes divider load, 9 steps and done, then the result load.
// Next word taken after the result load, which waits while the output word is held.
// Reset and every write to the row or column count reload the stack; entries below the
// lowest fill since reload read as index plus one. Needs fcsa_pkg, fcsa_ram, fcsa_divider.
module free_cell_stack_allocator_core #(
  parameter int unsigned MAX_ROWS    = fcsa_pkg::DefMaxRows,
  parameter int unsigned MAX_COLUMNS = fcsa_pkg::DefMaxColumns,
  parameter int unsigned STACK_DEPTH = fcsa_pkg::DefStackDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  fcsa_pkg::reg_t cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [4:0] row_in, [9:5] column_in, [15:10] zero
  input  logic [0:0]  s_axis_tuser,  // [0] opcode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [4:0] row_out, [9:5] column_out,
                                     // [18:10] free_count, [23:19] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);
  import fcsa_pkg::*;

  localparam int unsigned AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ResetFill = grid_fill(
      clamp_dim(reg_t'(RowCountReset), MAX_ROWS),
      clamp_dim(reg_t'(ColumnCountReset), MAX_COLUMNS), STACK_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  reg_t           rows_q, rows_d;
  reg_t           cols_q, cols_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] low_q, low_d;     // lowest fill since reload
  logic           use_rst_q, use_rst_d;
  logic [AW-1:0]  rd_idx_q, rd_idx_d;
  status_e        res_status_q, res_status_d;
  logic           res_div_q, res_div_d;

  logic           m_valid_q, m_valid_d;
  status_e        m_status_q, m_status_d;
  reg_t           m_row_q, m_row_d;
  reg_t           m_col_q, m_col_d;
  cell_t          m_count_q, m_count_d;

  reg_t           eff_cols;
  reg_t           row_in, col_in;
  logic           opcode;
  logic           accept;
  logic [FillW-1:0] fill_dec;
  logic [FillW-1:0] reload_fill;
  reg_t           cfg_rows, cfg_cols;
  logic           cfg_hit;

  cell_t          rm1;
  logic [2*CellW-1:0] rel_prod;
  cell_t          rel_cell;
  cell_t          pop_cell;

  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  cell_t          ram_rdata;
  logic           div_start;
  div_res_t       div_res;

  assign opcode   = s_axis_tuser[0];
  assign row_in   = s_axis_tdata[4:0];
  assign col_in   = s_axis_tdata[9:5];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign eff_cols = clamp_dim(cols_q, MAX_COLUMNS);
  assign fill_dec = fill_q - FillW'(1);

  // released cell number, modulo the cell width
  assign rm1      = cell_t'(row_in) - cell_t'(1);
  assign rel_prod = rm1 * cell_t'(eff_cols);
  assign rel_cell = rel_prod[CellW-1:0] + cell_t'(col_in);

  // untouched entries read as their reset value, index plus one
  assign pop_cell = use_rst_q ? cell_t'(32'(rd_idx_q) + 32'd1) : ram_rdata;

  assign cfg_hit  = cfg_we_i &&
                    (cfg_index_i == CFG_ROW_COUNT || cfg_index_i == CFG_COLUMN_COUNT);
  assign cfg_rows = (cfg_index_i == CFG_ROW_COUNT) ? cfg_data_i : rows_q;
  assign cfg_cols = (cfg_index_i == CFG_COLUMN_COUNT) ? cfg_data_i : cols_q;
  assign reload_fill = FillW'(grid_fill(clamp_dim(cfg_rows, MAX_ROWS),
                                        clamp_dim(cfg_cols, MAX_COLUMNS), STACK_DEPTH));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign div_start     = (state_q == ST_READ);

  always_comb begin
    state_d      = state_q;
    rows_d       = rows_q;
    cols_d       = cols_q;
    fill_d       = fill_q;
    low_d        = low_q;
    use_rst_d    = use_rst_q;
    rd_idx_d     = rd_idx_q;
    res_status_d = res_status_q;
    res_div_d    = res_div_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_status_d   = m_status_q;
    m_row_d      = m_row_q;
    m_col_d      = m_col_q;
    m_count_d    = m_count_q;
    ram_we       = 1'b0;
    ram_addr     = fill_dec[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_status_d = STATUS_OK;
          res_div_d    = 1'b0;
          state_d      = ST_DONE;
          if (opcode == OP_RESERVE) begin
            if (fill_q == '0) begin
              res_status_d = STATUS_EMPTY;
            end else begin
              fill_d    = fill_dec;
              use_rst_d = fill_dec < low_q;
              rd_idx_d  = fill_dec[AW-1:0];
              if (fill_dec < low_q) begin
                low_d = fill_dec;
              end
              res_div_d = 1'b1;
              state_d   = ST_READ;
            end
          end else begin
            if (32'(fill_q) >= STACK_DEPTH) begin
              res_status_d = STATUS_FULL;
            end else begin
              ram_we   = 1'b1;
              ram_addr = fill_q[AW-1:0];
              fill_d   = fill_q + FillW'(1);
            end
          end
        end
      end
      ST_READ: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // load the output word once the previous one has left
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_count_d  = cell_t'(fill_q);
          m_row_d    = res_div_q ? reg_t'(div_res.quot + cell_t'(1)) : '0;
          m_col_d    = res_div_q ? div_res.rem + reg_t'(1) : '0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_hit) begin
      rows_d = cfg_rows;
      cols_d = cfg_cols;
      fill_d = reload_fill;
      low_d  = reload_fill;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rows_q    <= reg_t'(RowCountReset);
      cols_q    <= reg_t'(ColumnCountReset);
      fill_q    <= FillW'(ResetFill);
      low_q     <= FillW'(ResetFill);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rows_q    <= rows_d;
      cols_q    <= cols_d;
      fill_q    <= fill_d;
      low_q     <= low_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    use_rst_q    <= use_rst_d;
    rd_idx_q     <= rd_idx_d;
    res_status_q <= res_status_d;
    res_div_q    <= res_div_d;
    m_status_q   <= m_status_d;
    m_row_q      <= m_row_d;
    m_col_q      <= m_col_d;
    m_count_q    <= m_count_d;
  end

  fcsa_ram #(
    .WIDTH (CellW),
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (rel_cell),
    .rdata_o (ram_rdata)
  );

  fcsa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pop_cell - cell_t'(1)),
    .divisor_i  (eff_cols),
    .res_o      (div_res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {5'b0, m_count_q, m_col_q, m_row_q};

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= STACK_DEPTH)
    else $error("stack fill beyond depth");

  a_low_below_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= fill_q)
    else $error("low-water mark above fill");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_DIV)
    else $error("divider finished outside divide state");

  a_div_result_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> res_div_q && res_status_q == STATUS_OK)
    else $error("divide started for a word that does not pop");

endmodule
